@@ hw/rtl/lltc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lltc_pkg
// Shared types and constants of the LCD line timing controller: mode codes,
// dot and line limits, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package lltc_pkg;

	localparam int DotW   = 10;
	localparam int TimerW = 9;
	localparam int LineW  = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 8;

	localparam logic [DotW-1:0]  OamEndDots  = 10'd80;
	localparam logic [DotW-1:0]  XferEndDots = 10'd252;
	localparam logic [DotW-1:0]  LineDots    = 10'd456;
	localparam logic [LineW-1:0] VblankLine  = 8'd144;
	localparam logic [LineW-1:0] LastLine    = 8'd153;

	typedef enum logic [1:0] {
		MODE_OAM    = 2'd0,
		MODE_XFER   = 2'd1,
		MODE_HBLANK = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_LY_COMPARE     = 3'd0,
		REG_IRQ_HBLANK_EN  = 3'd1,
		REG_IRQ_VBLANK_EN  = 3'd2,
		REG_IRQ_LYMATCH_EN = 3'd3,
		REG_IRQ_OAM_EN     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [LineW-1:0] ly_compare;
		logic             irq_hblank_en;
		logic             irq_vblank_en;
		logic             irq_lymatch_en;
		logic             irq_oam_en;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [TimerW-1:0] line_dots;
		logic [LineW-1:0]  line_cnt;
		logic              last_match;
		logic              ly_match;
	} timing_state_t;

	typedef struct packed {
		mode_t            mode;
		logic [LineW-1:0] line_number;
		logic             ly_match;
		logic             lcd_irq;
		logic             vblank_irq;
		logic             render_line;
		logic [LineW-1:0] render_line_number;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/lltc_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lltc_cfg_regs
// Configuration register file: line compare value and status interrupt enables.
// ----------------------------------------------------------------------------
module lltc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [lltc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [lltc_pkg::CfgDataW-1:0]  cfg_data,
	output lltc_pkg::cfg_t                      cfg
);

	lltc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lltc_pkg::REG_LY_COMPARE:     cfg_q.ly_compare     <= cfg_data;
				lltc_pkg::REG_IRQ_HBLANK_EN:  cfg_q.irq_hblank_en  <= cfg_data[0];
				lltc_pkg::REG_IRQ_VBLANK_EN:  cfg_q.irq_vblank_en  <= cfg_data[0];
				lltc_pkg::REG_IRQ_LYMATCH_EN: cfg_q.irq_lymatch_en <= cfg_data[0];
				lltc_pkg::REG_IRQ_OAM_EN:     cfg_q.irq_oam_en     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ hw/rtl/lltc_line_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lltc_line_step
// Next-state logic for one transaction: advances the dot timer, cascades the
// modes, handles the line end and forms the status condition.
// ----------------------------------------------------------------------------
module lltc_line_step (
	input  wire lltc_pkg::cfg_t               cfg,
	input  wire lltc_pkg::timing_state_t      cur,
	input  wire logic [7:0]                   dot_delta,
	output lltc_pkg::timing_state_t           nxt,
	output lltc_pkg::result_t                 res
);

	always_comb begin
		logic [lltc_pkg::DotW-1:0]  dots;
		logic [lltc_pkg::DotW-1:0]  wrapped;
		logic [lltc_pkg::LineW-1:0] new_cnt;
		logic                       reach_xfer;
		logic                       reach_hblank;
		logic                       hb_enter;
		logic                       hb_enter_wrap;
		logic                       invalid;
		logic                       line_end;
		logic                       at_vblank;
		logic                       visible;
		logic                       lym;
		logic                       match;
		lltc_pkg::mode_t            m;

		dots = {1'b0, cur.line_dots} + {2'b00, dot_delta};
		reach_xfer = 1'b0;
		reach_hblank = 1'b0;
		hb_enter = 1'b0;
		invalid = 1'b0;

		case (cur.mode)
			lltc_pkg::MODE_OAM: begin
				reach_xfer = dots >= lltc_pkg::OamEndDots;
				reach_hblank = dots >= lltc_pkg::XferEndDots;
				hb_enter = reach_hblank;
			end
			lltc_pkg::MODE_XFER: begin
				reach_xfer = 1'b1;
				reach_hblank = dots >= lltc_pkg::XferEndDots;
				hb_enter = reach_hblank;
			end
			lltc_pkg::MODE_HBLANK: begin
				reach_xfer = 1'b1;
				reach_hblank = 1'b1;
			end
			default: begin
				invalid = 1'b1;
			end
		endcase

		line_end = reach_hblank && (dots >= lltc_pkg::LineDots);
		wrapped = dots - lltc_pkg::LineDots;
		hb_enter_wrap = line_end && (wrapped >= lltc_pkg::XferEndDots);

		if (line_end) begin
			if (wrapped >= lltc_pkg::XferEndDots) begin
				m = lltc_pkg::MODE_HBLANK;
			end else if (wrapped >= lltc_pkg::OamEndDots) begin
				m = lltc_pkg::MODE_XFER;
			end else begin
				m = lltc_pkg::MODE_OAM;
			end
		end else if (invalid) begin
			m = lltc_pkg::MODE_OAM;
		end else if (reach_hblank) begin
			m = lltc_pkg::MODE_HBLANK;
		end else if (reach_xfer) begin
			m = lltc_pkg::MODE_XFER;
		end else begin
			m = lltc_pkg::MODE_OAM;
		end

		new_cnt = (cur.line_cnt >= lltc_pkg::LastLine) ? '0 : cur.line_cnt + 8'd1;
		visible = cur.line_cnt < lltc_pkg::VblankLine;
		at_vblank = cur.line_cnt == lltc_pkg::VblankLine;
		lym = new_cnt == cfg.ly_compare;

		match = (cfg.irq_hblank_en && (hb_enter || hb_enter_wrap))
			|| (line_end && ((cfg.irq_vblank_en && at_vblank)
				|| (cfg.irq_lymatch_en && lym) || cfg.irq_oam_en));

		nxt.mode = m;
		nxt.line_dots = line_end ? wrapped[lltc_pkg::TimerW-1:0]
			: dots[lltc_pkg::TimerW-1:0];
		nxt.line_cnt = line_end ? new_cnt : cur.line_cnt;
		nxt.ly_match = line_end ? lym : cur.ly_match;
		nxt.last_match = match;

		res.mode = m;
		res.line_number = nxt.line_cnt;
		res.ly_match = nxt.ly_match;
		res.lcd_irq = match && !cur.last_match;
		res.vblank_irq = line_end && at_vblank;
		res.render_line = line_end && visible;
		res.render_line_number = (line_end && visible) ? cur.line_cnt : '0;
	end

endmodule
`default_nettype wire

@@ hw/rtl/lcd_line_timing_controller.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_line_timing_controller
// LCD line timer with mode sequencing, line counter and status interrupts.
// pipeline: input register, then result register, from input transaction to result
// throughput: one transaction per cycle; a held result (out_ready low) stalls it
// reset: arst_n clears timer, mode, line counter, flags and config registers
// ----------------------------------------------------------------------------
module lcd_line_timing_controller (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_ready,
	input  wire logic [7:0]                     dot_delta,
	output      logic                           out_valid,
	input  wire logic                           out_ready,
	output      logic [1:0]                     mode,
	output      logic [7:0]                     line_number,
	output      logic                           ly_match,
	output      logic                           lcd_irq,
	output      logic                           vblank_irq,
	output      logic                           render_line,
	output      logic [7:0]                     render_line_number,
	input  wire logic                           cfg_we,
	input  wire logic [lltc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [lltc_pkg::CfgDataW-1:0]  cfg_data
);

	lltc_pkg::cfg_t          cfg;
	lltc_pkg::timing_state_t state_q;
	lltc_pkg::timing_state_t state_nxt;
	lltc_pkg::result_t       res_nxt;
	lltc_pkg::result_t       res_s2;
	logic                    valid_s1;
	logic [7:0]              delta_s1;
	logic                    valid_s2;
	logic                    advance;

	lltc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lltc_line_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.dot_delta (delta_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	assign advance = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			delta_s1 <= dot_delta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign mode = res_s2.mode;
	assign line_number = res_s2.line_number;
	assign ly_match = res_s2.ly_match;
	assign lcd_irq = res_s2.lcd_irq;
	assign vblank_irq = res_s2.vblank_irq;
	assign render_line = res_s2.render_line;
	assign render_line_number = res_s2.render_line_number;

`ifndef SYNTHESIS
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.line_cnt <= lltc_pkg::LastLine)
		else $error("line counter out of range");

	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode != 2'd3)
		else $error("invalid mode stored");

	a_timer_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, state_q.line_dots} < lltc_pkg::LineDots)
		else $error("line timer past line end");

	a_render_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && render_line |-> line_number == render_line_number + 8'd1)
		else $error("rendered line does not precede current line");

	a_vblank_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vblank_irq |-> line_number == lltc_pkg::VblankLine + 8'd1)
		else $error("vblank raised on wrong line");
`endif

endmodule
`default_nettype wire

@@ bench/line_timing_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_timing_checker
// Watches the input, result and register write ports of the LCD line timing
// controller. Keeps its own copy of the line timer, mode, line counter and
// interrupt edge state, predicts the result of every accepted transaction
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module line_timing_checker
	import lltc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [7:0]          dot_delta,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          mode,
	input  logic [7:0]          line_number,
	input  logic                ly_match,
	input  logic                lcd_irq,
	input  logic                vblank_irq,
	input  logic                render_line,
	input  logic [7:0]          render_line_number,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int                  errors,
	output int                  outstanding
);

	cfg_t             cfg_shadow;
	mode_t            mode_st;
	logic [TimerW-1:0] dots_st;
	logic [LineW-1:0] line_st;
	logic             last_match_st;
	logic             ly_match_st;
	result_t          line_results_q[$];
	result_t          got;
	result_t          want;

	function automatic result_t advance_timing(input logic [7:0] delta);
		logic [9:0] dots;
		mode_t      m;
		logic       hit;
		logic       line_end;
		result_t    r;
		r = '0;
		hit = 1'b0;
		dots = 10'(dots_st) + 10'(delta);
		m = mode_st;
		for (int pass = 0; pass < 2; pass++) begin
			line_end = 1'b0;
			if (m != MODE_OAM && m != MODE_XFER && m != MODE_HBLANK) begin
				m = MODE_OAM;
				break;
			end
			if (m == MODE_OAM) begin
				if (dots < OamEndDots) break;
				m = MODE_XFER;
			end
			if (m == MODE_XFER) begin
				if (dots < XferEndDots) break;
				m = MODE_HBLANK;
				if (cfg_shadow.irq_hblank_en) hit = 1'b1;
			end
			if (m == MODE_HBLANK) begin
				if (dots < LineDots) break;
				dots = dots - LineDots;
				line_end = 1'b1;
			end
			if (!line_end) break;

			if (line_st < VblankLine) begin
				r.render_line = 1'b1;
				r.render_line_number = line_st;
			end else if (line_st == VblankLine) begin
				if (cfg_shadow.irq_vblank_en) hit = 1'b1;
				r.vblank_irq = 1'b1;
			end
			line_st = (line_st >= LastLine) ? '0 : line_st + 8'd1;
			// compare flag only refreshes at a line end
			ly_match_st = (line_st == cfg_shadow.ly_compare);
			if (ly_match_st && cfg_shadow.irq_lymatch_en) hit = 1'b1;
			if (cfg_shadow.irq_oam_en) hit = 1'b1;
			m = MODE_OAM;
		end
		mode_st = m;
		dots_st = dots[TimerW-1:0];
		r.mode = m;
		r.line_number = line_st;
		r.ly_match = ly_match_st;
		r.lcd_irq = hit && !last_match_st;
		last_match_st = hit;
		return r;
	endfunction

	task automatic flag_failure();
		errors++;
		if (errors <= 10) begin
			$display("%0t mismatch: expected mode=%0d line=%0d ly_match=%0b lcd_irq=%0b",
				$time, want.mode, want.line_number, want.ly_match, want.lcd_irq);
			$display("    vblank_irq=%0b render_line=%0b render_line_number=%0d",
				want.vblank_irq, want.render_line, want.render_line_number);
			$display("    got mode=%0d line=%0d ly_match=%0b lcd_irq=%0b",
				got.mode, got.line_number, got.ly_match, got.lcd_irq);
			$display("    vblank_irq=%0b render_line=%0b render_line_number=%0d",
				got.vblank_irq, got.render_line, got.render_line_number);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_shadow = '0;
			mode_st = MODE_OAM;
			dots_st = '0;
			line_st = '0;
			last_match_st = 1'b0;
			ly_match_st = 1'b0;
			line_results_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_LY_COMPARE:     cfg_shadow.ly_compare = cfg_data[LineW-1:0];
					REG_IRQ_HBLANK_EN:  cfg_shadow.irq_hblank_en = cfg_data[0];
					REG_IRQ_VBLANK_EN:  cfg_shadow.irq_vblank_en = cfg_data[0];
					REG_IRQ_LYMATCH_EN: cfg_shadow.irq_lymatch_en = cfg_data[0];
					REG_IRQ_OAM_EN:     cfg_shadow.irq_oam_en = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got.mode = mode_t'(mode);
				got.line_number = line_number;
				got.ly_match = ly_match;
				got.lcd_irq = lcd_irq;
				got.vblank_irq = vblank_irq;
				got.render_line = render_line;
				got.render_line_number = render_line_number;
				if (line_results_q.size() == 0) begin
					want = 'x;
					flag_failure();
				end else begin
					want = line_results_q.pop_front();
					if (got.mode !== want.mode
						|| got.line_number !== want.line_number
						|| got.ly_match !== want.ly_match
						|| got.lcd_irq !== want.lcd_irq
						|| got.vblank_irq !== want.vblank_irq
						|| got.render_line !== want.render_line
						|| got.render_line_number !== want.render_line_number)
						flag_failure();
				end
			end
			if (in_valid && in_ready)
				line_results_q.push_back(advance_timing(dot_delta));
			outstanding = line_results_q.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives dot count transactions into the LCD line timing controller under
// several register settings: a short directed run over the mode boundaries
// and line ends, then random phases with bursty input, stalling output and
// one long output hold. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import lltc_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int HoldCycles = 300;
	localparam int PhaseItems = 300;

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_HOLD} rx_profile_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [7:0]          dot_delta = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [1:0]          mode;
	logic [7:0]          line_number;
	logic                ly_match;
	logic                lcd_irq;
	logic                vblank_irq;
	logic                render_line;
	logic [7:0]          render_line_number;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_LY_COMPARE;
	logic [CfgDataW-1:0] cfg_data = '0;
	int                  errors;
	int                  outstanding;

	rx_profile_t rx_profile = RX_ALWAYS;
	bit          sender_gaps = 1'b0;
	int          burst_left = 0;
	int          hold_count = 0;
	int          rx_step = 0;
	int          cycles = 0;
	logic [10:0] rx_pattern = 11'b101_1101_0110;

	lcd_line_timing_controller DUT (.*);
	line_timing_checker u_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver stall profiles, with one long hold to back up the pipeline
	always @(negedge clk) begin
		rx_step++;
		if (rx_profile == RX_HOLD && hold_count < HoldCycles) begin
			hold_count++;
			out_ready <= 1'b0;
		end else begin
			case (rx_profile)
				RX_ALWAYS:  out_ready <= 1'b1;
				RX_PATTERN: out_ready <= rx_pattern[rx_step % 11];
				default:    out_ready <= ($urandom_range(0, 99) < 65);
			endcase
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_dots(input logic [7:0] delta);
		int gap;
		if (burst_left == 0) begin
			gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
			burst_left = $urandom_range(1, 24);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
				dot_delta <= 8'($urandom);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		dot_delta <= delta;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_dots();
		case ($urandom_range(0, 9))
			0:       return 8'd0;
			1:       return 8'd255;
			2, 3:    return 8'($urandom_range(1, 8));
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin
		logic [7:0] compare_val;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk each mode boundary exactly, then cascade across a line end
		send_dots(8'd0);
		send_dots(8'd79);
		send_dots(8'd1);
		send_dots(8'd171);
		send_dots(8'd1);
		send_dots(8'd203);
		send_dots(8'd1);
		send_dots(8'd255);
		send_dots(8'd255);
		drain();

		write_reg(REG_LY_COMPARE, 8'd2);
		write_reg(REG_IRQ_HBLANK_EN, 8'd1);
		write_reg(REG_IRQ_VBLANK_EN, 8'd1);
		write_reg(REG_IRQ_LYMATCH_EN, 8'd1);
		write_reg(REG_IRQ_OAM_EN, 8'd1);
		rx_profile = RX_RANDOM;
		sender_gaps = 1'b1;
		for (int i = 0; i < 8; i++)
			send_dots(i[0] ? 8'd255 : 8'd200);
		drain();

		// compare written mid-line: flag holds until the next line end
		write_reg(REG_LY_COMPARE, 8'd6);
		send_dots(8'd0);
		send_dots(8'd255);
		send_dots(8'd255);
		send_dots(8'd255);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       compare_val = 8'd255;
				1:       compare_val = 8'd0;
				2:       compare_val = 8'd144;
				3:       compare_val = 8'd153;
				default: compare_val = ($urandom_range(0, 3) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 153));
			endcase
			write_reg(REG_LY_COMPARE, compare_val);
			write_reg(REG_IRQ_HBLANK_EN, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0
				: 8'($urandom_range(0, 1)));
			write_reg(REG_IRQ_VBLANK_EN, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0
				: 8'($urandom_range(0, 1)));
			write_reg(REG_IRQ_LYMATCH_EN, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0
				: 8'($urandom_range(0, 1)));
			write_reg(REG_IRQ_OAM_EN, (phase == 0) ? 8'd1 : (phase == 1) ? 8'd0
				: 8'($urandom_range(0, 1)));
			case (phase)
				0, 4:    rx_profile = RX_RANDOM;
				1, 5:    rx_profile = RX_PATTERN;
				2:       rx_profile = RX_HOLD;
				default: rx_profile = RX_ALWAYS;
			endcase
			sender_gaps = (phase != 2 && phase != 3);
			burst_left = 0;
			for (int i = 0; i < PhaseItems; i++)
				send_dots(pick_dots());
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/lltc_pkg.sv
hw/rtl/lltc_cfg_regs.sv
hw/rtl/lltc_line_step.sv
hw/rtl/lcd_line_timing_controller.sv
bench/line_timing_checker.sv
bench/testbench.sv
